// File: hdl/kct_pkg.sv
// Shared types, constants and key decode for the keypad countdown timer.
// No dependencies; imported by every module of the block.
`default_nettype none

package kct_pkg;

  // Field and register widths
  localparam int TICK_W  = 8;
  localparam int BUZZ_W  = 9;
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 3;
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 5;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 9;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 24;

  // Event kinds carried in the input tuser
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUZZ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY  = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_TPS     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REFRESH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BUZZ    = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0] TPS_RESET     = 8'd20;
  localparam logic [TICK_W-1:0] REFRESH_RESET = 8'd8;
  localparam logic [BUZZ_W-1:0] BUZZ_RESET    = 9'd300;

  // Function keys
  localparam logic [KEY_W-1:0] KEY_START   = 5'd16;
  localparam logic [KEY_W-1:0] KEY_COMMIT  = 5'd15;
  localparam logic [KEY_W-1:0] KEY_PAUSE   = 5'd13;
  localparam logic [KEY_W-1:0] KEY_DISPLAY = 5'd12;

  // Digit limits and entry positions
  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;
  localparam logic [DIGIT_W-1:0] SEC_TENS_MAX = 4'd5;
  localparam logic [KEY_W-1:0]   NO_DIGIT     = 5'd16;
  localparam logic [POS_W-1:0]   POS_NONE     = 3'd0;
  localparam logic [POS_W-1:0]   POS_SEC_ONES = 3'd1;
  localparam logic [POS_W-1:0]   POS_SEC_TENS = 3'd2;
  localparam logic [POS_W-1:0]   POS_FIRST    = 3'd4;

  typedef logic [3:0][DIGIT_W-1:0] bcd4_t;

  typedef struct packed {
    logic [BUZZ_W-1:0] buzzer_ticks;
    logic [TICK_W-1:0] refresh_ticks;
    logic [TICK_W-1:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [TICK_W-1:0] sec_rem;
    logic [TICK_W-1:0] ref_rem;
  } div_load_t;

  // Result item, last member in the lowest bits
  typedef struct packed {
    logic               is_setting;
    logic               is_paused;
    logic               buzzer;
    logic               show_countdown;
    logic [2:0]         blank_digit;
    logic [DIGIT_W-1:0] seconds_ones;
    logic [2:0]         seconds_tens;
    logic [DIGIT_W-1:0] minutes_ones;
    logic [DIGIT_W-1:0] minutes_tens;
  } result_t;

  // Keypad layout: digit for each key number, NO_DIGIT for others
  function automatic logic [KEY_W-1:0] key_digit(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] d;
    case (key)
      5'd1:    d = 5'd7;
      5'd2:    d = 5'd8;
      5'd3:    d = 5'd9;
      5'd5:    d = 5'd4;
      5'd6:    d = 5'd5;
      5'd7:    d = 5'd6;
      5'd9:    d = 5'd1;
      5'd10:   d = 5'd2;
      5'd11:   d = 5'd3;
      5'd14:   d = 5'd0;
      default: d = NO_DIGIT;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kct_divrem.sv
// Iterative remainder unit: dividend mod divisor, one restoring step per cycle.
// Uses kct_pkg for widths.
`default_nettype none

module kct_divrem
  import kct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TICK_W-1:0] dividend,
  input  wire logic [TICK_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [TICK_W-1:0]      rem
);

  localparam int STEP_W = $clog2(TICK_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TICK_W - 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TICK_W-1:0] dvd_r, dvd_nxt;
  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [TICK_W:0]   shifted;
  logic [TICK_W:0]   diff;

  // One restoring step
  always_comb begin
    shifted  = {rem_r, dvd_r[TICK_W-1]};
    diff     = shifted - {1'b0, divisor};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_LAST;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (run_r) begin
      rem_nxt = (shifted >= {1'b0, divisor}) ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
      dvd_nxt = {dvd_r[TICK_W-2:0], 1'b0};
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = run_r | done_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: hdl/kct_core.sv
// Timer state and combinational event update; holds the result register.
// Uses kct_pkg for types, codes and the key decode.
`default_nettype none

module kct_core
  import kct_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [KEY_W-1:0]  key,
  input  wire cfg_t              cfg,
  input  wire div_load_t         ld,
  output logic [TICK_W-1:0]      tick_count,
  output result_t                res
);

  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] sec_rem_r, sec_rem_nxt;
  logic [TICK_W-1:0] ref_rem_r, ref_rem_nxt;
  bcd4_t             remain_r, remain_nxt;
  bcd4_t             digits_r, digits_nxt;
  logic              halted_r, halted_nxt;
  logic              entry_r, entry_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              blink_r, blink_nxt;
  logic              blank_r, blank_nxt;
  logic              disp_r, disp_nxt;
  logic              pending_r, pending_nxt;
  logic              buzz_r, buzz_nxt;
  logic [BUZZ_W-1:0] bcnt_r, bcnt_nxt;
  result_t           res_r, res_nxt;

  logic [TICK_W-1:0] sec_inc, ref_inc;
  logic              sec_hit, ref_hit;
  bcd4_t             remain_dec;
  logic [BUZZ_W-1:0] bcnt_inc;
  logic [KEY_W-1:0]  num;
  logic [1:0]        wr_idx;

  // mm:ss decrement with borrow across digits
  function automatic bcd4_t bcd_dec(input bcd4_t v);
    bcd4_t r;
    r = v;
    if (v[0] != '0) begin
      r[0] = v[0] - 1'b1;
    end else begin
      r[0] = DIGIT_MAX;
      if (v[1] != '0) begin
        r[1] = v[1] - 1'b1;
      end else begin
        r[1] = SEC_TENS_MAX;
        if (v[2] != '0) begin
          r[2] = v[2] - 1'b1;
        end else begin
          r[2] = DIGIT_MAX;
          r[3] = v[3] - 1'b1;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    tick_nxt    = tick_r;
    sec_rem_nxt = sec_rem_r;
    ref_rem_nxt = ref_rem_r;
    remain_nxt  = remain_r;
    digits_nxt  = digits_r;
    halted_nxt  = halted_r;
    entry_nxt   = entry_r;
    pos_nxt     = pos_r;
    blink_nxt   = blink_r;
    blank_nxt   = blank_r;
    disp_nxt    = disp_r;
    pending_nxt = pending_r;
    buzz_nxt    = buzz_r;
    bcnt_nxt    = bcnt_r;
    sec_inc     = sec_rem_r + 1'b1;
    ref_inc     = ref_rem_r + 1'b1;
    sec_hit     = 1'b0;
    ref_hit     = 1'b0;
    remain_dec  = bcd_dec(remain_r);
    bcnt_inc    = bcnt_r + 1'b1;
    num         = key_digit(key);
    wr_idx      = 2'(pos_r - POS_SEC_ONES);

    // Fresh tick remainders after a register write
    if (ld.load) begin
      sec_rem_nxt = ld.sec_rem;
      ref_rem_nxt = ld.ref_rem;
    end

    if (adv) begin
      case (mode)
        MODE_TICK: begin
          tick_nxt = tick_r + 1'b1;
          // Remainders track tick_count mod each divisor; wrap restarts at zero
          if (tick_nxt == '0) begin
            sec_rem_nxt = '0;
            ref_rem_nxt = '0;
          end else begin
            sec_rem_nxt = (sec_inc == cfg.ticks_per_second) ? '0 : sec_inc;
            ref_rem_nxt = (ref_inc == cfg.refresh_ticks) ? '0 : ref_inc;
          end
          sec_hit = (cfg.ticks_per_second != '0) && (sec_rem_nxt == '0);
          ref_hit = (cfg.refresh_ticks != '0) && (ref_rem_nxt == '0);
          // One second elapsed
          if (sec_hit && !halted_r) begin
            if (remain_r != '0) begin
              remain_nxt = remain_dec;
              if (remain_dec == '0) pending_nxt = 1'b1;
            end
            digits_nxt = remain_nxt;
          end
          // Display refresh and blink
          if (ref_hit) begin
            if (disp_r) begin
              blank_nxt = (pos_r != POS_NONE) && blink_r;
              blink_nxt = !blink_r;
            end else begin
              blank_nxt = 1'b0;
            end
          end
          // Alarm start
          if ((remain_nxt == '0) && pending_nxt) begin
            buzz_nxt    = 1'b1;
            pending_nxt = 1'b0;
          end
        end
        MODE_BUZZ: begin
          if (buzz_r) begin
            if (bcnt_inc >= cfg.buzzer_ticks) begin
              buzz_nxt    = 1'b0;
              bcnt_nxt    = '0;
              pending_nxt = 1'b0;
            end else begin
              bcnt_nxt = bcnt_inc;
            end
          end
        end
        MODE_KEY: begin
          if (key == KEY_START) begin
            entry_nxt  = 1'b1;
            halted_nxt = 1'b1;
            pos_nxt    = POS_FIRST;
          end else if (key == KEY_COMMIT) begin
            remain_nxt  = digits_r;
            entry_nxt   = 1'b0;
            halted_nxt  = 1'b0;
            pos_nxt     = POS_NONE;
            pending_nxt = 1'b0;
          end else if (key == KEY_PAUSE && !entry_r) begin
            halted_nxt = !halted_r;
          end else if (key == KEY_DISPLAY) begin
            disp_nxt = !disp_r;
          end else if (entry_r && num <= KEY_W'(DIGIT_MAX)) begin
            // Digit into the blinking position; seconds tens capped
            if (pos_r == POS_SEC_TENS && num > KEY_W'(SEC_TENS_MAX)) begin
              num = KEY_W'(SEC_TENS_MAX);
            end
            if (pos_r >= POS_SEC_ONES && pos_r <= POS_FIRST) begin
              digits_nxt[wr_idx] = num[DIGIT_W-1:0];
            end
            pos_nxt = (pos_r > POS_SEC_ONES) ? pos_r - 1'b1 : POS_FIRST;
          end
        end
        default: ;
      endcase
    end

    // Result from the updated state
    res_nxt = res_r;
    if (adv) begin
      res_nxt.minutes_tens   = digits_nxt[3];
      res_nxt.minutes_ones   = digits_nxt[2];
      res_nxt.seconds_tens   = digits_nxt[1][2:0];
      res_nxt.seconds_ones   = digits_nxt[0];
      res_nxt.blank_digit    = blank_nxt ? pos_nxt : POS_NONE;
      res_nxt.show_countdown = disp_nxt;
      res_nxt.buzzer         = buzz_nxt;
      res_nxt.is_paused      = halted_nxt;
      res_nxt.is_setting     = entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      sec_rem_r <= '0;
      ref_rem_r <= '0;
      remain_r  <= '0;
      digits_r  <= '0;
      halted_r  <= 1'b0;
      entry_r   <= 1'b0;
      pos_r     <= POS_NONE;
      blink_r   <= 1'b0;
      blank_r   <= 1'b0;
      disp_r    <= 1'b0;
      pending_r <= 1'b0;
      buzz_r    <= 1'b0;
      bcnt_r    <= '0;
      res_r     <= '0;
    end else begin
      tick_r    <= tick_nxt;
      sec_rem_r <= sec_rem_nxt;
      ref_rem_r <= ref_rem_nxt;
      remain_r  <= remain_nxt;
      digits_r  <= digits_nxt;
      halted_r  <= halted_nxt;
      entry_r   <= entry_nxt;
      pos_r     <= pos_nxt;
      blink_r   <= blink_nxt;
      blank_r   <= blank_nxt;
      disp_r    <= disp_nxt;
      pending_r <= pending_nxt;
      buzz_r    <= buzz_nxt;
      bcnt_r    <= bcnt_nxt;
      res_r     <= res_nxt;
    end
  end

  assign tick_count = tick_r;
  assign res        = res_r;

endmodule

`default_nettype wire

// File: hdl/keypad_countdown_timer.sv
// Keypad countdown timer: input register, combinational state update, result register.
// Each input passes the input register, then the result register; one item per cycle unless
// the result channel stalls or a register write is pending. A write re-derives the tick
// remainders in two iterative units (8 steps, one bit per cycle); input waits for both.
// Reset (rst_n low, synchronous) clears all timer state and loads register defaults.
// Depends on kct_pkg, kct_divrem and kct_core.
`default_nettype none

module keypad_countdown_timer
  import kct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_W-1:0]    in_tdata,   // key[4:0], zero pad
  input  wire logic [MODE_W-1:0]  in_tuser,   // mode[1:0]
  // result channel
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_W-1:0]        out_tdata,  // minutes_tens[3:0], minutes_ones[7:4],
                                              // seconds_tens[10:8], seconds_ones[14:11],
                                              // blank_digit[17:15], show_countdown[18],
                                              // buzzer[19], is_paused[20],
                                              // is_setting[21], zero pad
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  logic              start_r;
  logic              in_valid_r, in_valid_nxt;
  logic [MODE_W-1:0] in_mode_r;
  logic [KEY_W-1:0]  in_key_r;
  logic              out_valid_r, out_valid_nxt;
  logic              advance;
  logic              in_xfer;
  logic              sec_busy, ref_busy, sec_done, ref_done;
  logic [TICK_W-1:0] sec_rem, ref_rem;
  logic [TICK_W-1:0] tick_count;
  div_load_t         ld;
  result_t           res;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TPS:     cfg_nxt.ticks_per_second = cfg_wdata[TICK_W-1:0];
        CFG_REFRESH: cfg_nxt.refresh_ticks    = cfg_wdata[TICK_W-1:0];
        CFG_BUZZ:    cfg_nxt.buzzer_ticks     = cfg_wdata[BUZZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input stage advances when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !cfg_we && !start_r && !sec_busy && !ref_busy
                     && (!in_valid_r || advance);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= TPS_RESET;
      cfg_r.refresh_ticks    <= REFRESH_RESET;
      cfg_r.buzzer_ticks     <= BUZZ_RESET;
      start_r                <= 1'b0;
      in_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      start_r     <= cfg_we;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_xfer) begin
      in_mode_r <= in_tuser;
      in_key_r  <= in_tdata[KEY_W-1:0];
    end
  end

  // Tick count modulo each divisor, recomputed after a write
  kct_divrem u_sec_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (tick_count),
    .divisor  (cfg_r.ticks_per_second),
    .busy     (sec_busy),
    .done     (sec_done),
    .rem      (sec_rem)
  );

  kct_divrem u_ref_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (tick_count),
    .divisor  (cfg_r.refresh_ticks),
    .busy     (ref_busy),
    .done     (ref_done),
    .rem      (ref_rem)
  );

  assign ld.load    = sec_done & ref_done;
  assign ld.sec_rem = sec_rem;
  assign ld.ref_rem = ref_rem;

  kct_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (advance),
    .mode       (in_mode_r),
    .key        (in_key_r),
    .cfg        (cfg_r),
    .ld         (ld),
    .tick_count (tick_count),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(res);

endmodule

`default_nettype wire

// File: tb/sv/tb_keypad_countdown_timer.sv
// Self-checking testbench for keypad_countdown_timer: drives tick, buzzer and key events,
// predicts each display/status result in a behavioral timer model and checks every transfer.
// Depends on kct_pkg and the keypad_countdown_timer RTL.
`default_nettype none

module tb_keypad_countdown_timer;
  import kct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Event kind with no effect, and keys that are outside the digit set
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_NONE  = 5'd0;
  localparam logic [KEY_W-1:0]  KEY_HASH  = 5'd4;
  localparam logic [KEY_W-1:0]  KEY_STAR  = 5'd8;
  localparam logic [KEY_W-1:0]  KEY_TOP   = 5'd31;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } kp_event_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic [MODE_W-1:0]  in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_wdata = '0;

  keypad_countdown_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending input events and expected display words
  kp_event_t event_q[$];
  result_t   display_q[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Timer model: register copies and state
  int cfg_tps = TPS_RESET;
  int cfg_refresh = REFRESH_RESET;
  int cfg_buzz = BUZZ_RESET;
  int tick_cnt = 0;
  int secs_left = 0;
  int dig[4] = '{0, 0, 0, 0};
  bit halted = 0;
  bit entering = 0;
  int entry_pos = 0;
  bit blink = 0;
  bit blank = 0;
  bit show_cd = 0;
  bit alarm = 0;
  bit buzz_on = 0;
  int buzz_cnt = 0;

  // Keypad layout: key number for each digit value
  function automatic logic [KEY_W-1:0] key_for_digit(input int d);
    logic [KEY_W-1:0] k;
    case (d)
      0:       k = 5'd14;
      1:       k = 5'd9;
      2:       k = 5'd10;
      3:       k = 5'd11;
      4:       k = 5'd5;
      5:       k = 5'd6;
      6:       k = 5'd7;
      7:       k = 5'd1;
      8:       k = 5'd2;
      default: k = 5'd3;
    endcase
    return k;
  endfunction

  // Apply one event to the timer model and form the display it reports
  task automatic timer_step(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            output result_t res);
    int num;
    num = 16;
    case (mode)
      MODE_TICK: begin
        tick_cnt = (tick_cnt + 1) % 256;
        if (cfg_tps != 0 && tick_cnt % cfg_tps == 0 && !halted) begin
          if (secs_left > 0) begin
            secs_left--;
            if (secs_left == 0) alarm = 1;
          end
          dig[3] = (secs_left / 600) % 10;
          dig[2] = (secs_left / 60) % 10;
          dig[1] = (secs_left % 60) / 10;
          dig[0] = secs_left % 10;
        end
        if (cfg_refresh != 0 && tick_cnt % cfg_refresh == 0) begin
          if (show_cd) begin
            blank = (entry_pos > 0) && blink;
            blink = !blink;
          end else begin
            blank = 0;
          end
        end
        if (secs_left == 0 && alarm) begin
          buzz_on = 1;
          alarm = 0;
        end
      end
      MODE_BUZZ: begin
        if (buzz_on) begin
          buzz_cnt = (buzz_cnt + 1) % 512;
          if (buzz_cnt >= cfg_buzz) begin
            buzz_on = 0;
            buzz_cnt = 0;
            alarm = 0;
          end
        end
      end
      MODE_KEY: begin
        if (key == KEY_START) begin
          entering = 1;
          halted = 1;
          entry_pos = POS_FIRST;
        end else if (key == KEY_COMMIT) begin
          secs_left = (dig[3] * 600 + dig[2] * 60 + dig[1] * 10 + dig[0]) % 8192;
          entering = 0;
          halted = 0;
          entry_pos = POS_NONE;
          alarm = 0;
        end else if (key == KEY_PAUSE && !entering) begin
          halted = !halted;
        end else if (key == KEY_DISPLAY) begin
          show_cd = !show_cd;
        end else if (entering) begin
          for (int d = 0; d < 10; d++)
            if (key_for_digit(d) == key) num = d;
          if (num <= 9) begin
            // seconds tens can hold 5 at most
            if (entry_pos == POS_SEC_TENS && num > SEC_TENS_MAX) num = SEC_TENS_MAX;
            if (entry_pos >= 1 && entry_pos <= 4) dig[entry_pos - 1] = num;
            entry_pos = (entry_pos > 1) ? entry_pos - 1 : POS_FIRST;
          end
        end
      end
      default: ;
    endcase
    res.minutes_tens   = DIGIT_W'(dig[3]);
    res.minutes_ones   = DIGIT_W'(dig[2]);
    res.seconds_tens   = 3'(dig[1]);
    res.seconds_ones   = DIGIT_W'(dig[0]);
    res.blank_digit    = blank ? POS_W'(entry_pos) : POS_NONE;
    res.show_countdown = show_cd;
    res.buzzer         = buzz_on;
    res.is_paused      = halted;
    res.is_setting     = entering;
  endtask

  // Input driver: launches queued events, predicts each accepted transfer
  kp_event_t next_ev;
  result_t   predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        timer_step(in_tuser, in_tdata[KEY_W-1:0], predicted);
        display_q.push_back(predicted);
      end
      if (!in_tvalid || in_tready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_ev = event_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_ev.mode;
          in_tdata  <= {{(IN_W-KEY_W){1'b0}}, next_ev.key};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  // Result monitor: compares each transfer with the oldest expected display
  result_t want_res;
  result_t got_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (display_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %h arrived with nothing expected", out_tdata);
      end else begin
        want_res = display_q.pop_front();
        check_field("minutes_tens", want_res.minutes_tens, got_res.minutes_tens);
        check_field("minutes_ones", want_res.minutes_ones, got_res.minutes_ones);
        check_field("seconds_tens", want_res.seconds_tens, got_res.seconds_tens);
        check_field("seconds_ones", want_res.seconds_ones, got_res.seconds_ones);
        check_field("blank_digit", want_res.blank_digit, got_res.blank_digit);
        check_field("show_countdown", want_res.show_countdown, got_res.show_countdown);
        check_field("buzzer", want_res.buzzer, got_res.buzzer);
        check_field("is_paused", want_res.is_paused, got_res.is_paused);
        check_field("is_setting", want_res.is_setting, got_res.is_setting);
      end
    end
  end

  task automatic push_ev(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
    kp_event_t e;
    e.mode = mode;
    e.key  = key;
    event_q.push_back(e);
  endtask

  // Sampled at the falling edge so posedge updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (event_q.size() != 0 || in_tvalid || display_q.size() != 0) @(negedge clk);
  endtask

  // Register writes only once the block has drained
  task automatic set_regs(input int tps, input int refr, input int buzz);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TPS;
    cfg_wdata <= CDATA_W'(tps);
    @(posedge clk);
    cfg_index <= CFG_REFRESH;
    cfg_wdata <= CDATA_W'(refr);
    @(posedge clk);
    cfg_index <= CFG_BUZZ;
    cfg_wdata <= CDATA_W'(buzz);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_tps     = tps % 256;
    cfg_refresh = refr % 256;
    cfg_buzz    = buzz % 512;
  endtask

  // One user session: mostly a full entry and commit followed by ticks and other events, else noise
  task automatic queue_session(output int n);
    int r;
    int len;
    int d;
    n = 0;
    if ($urandom_range(99) < 85) begin
      push_ev(MODE_KEY, KEY_START);
      n++;
      for (int p = 4; p >= 1; p--) begin
        r = $urandom_range(99);
        if (r < 6) begin
          push_ev(MODE_KEY, ($urandom_range(1) != 0) ? KEY_HASH : KEY_STAR);
          n++;
        end else if (r < 14) begin
          push_ev(MODE_TICK, KEY_W'($urandom_range(31)));
          n++;
        end else if (r < 17) begin
          push_ev(MODE_KEY, KEY_DISPLAY);
          n++;
        end
        if (p >= 3) d = ($urandom_range(99) < 85) ? 0 : $urandom_range(9);
        else if (p == 2) d = ($urandom_range(99) < 75) ? 0 : $urandom_range(9);
        else d = $urandom_range(9);
        push_ev(MODE_KEY, key_for_digit(d));
        n++;
      end
      if ($urandom_range(99) < 90) begin
        push_ev(MODE_KEY, KEY_COMMIT);
        n++;
      end
      len = $urandom_range(10, 80);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 65) push_ev(MODE_TICK, KEY_W'($urandom_range(31)));
        else if (r < 85) push_ev(MODE_BUZZ, KEY_W'($urandom_range(31)));
        else if (r < 90) push_ev(MODE_KEY, KEY_DISPLAY);
        else if (r < 94) push_ev(MODE_KEY, KEY_PAUSE);
        else if (r < 97) push_ev(MODE_NONE, KEY_W'($urandom_range(31)));
        else push_ev(MODE_KEY, KEY_W'($urandom_range(31)));
        n++;
      end
    end else begin
      len = $urandom_range(6, 12);
      for (int i = 0; i < len; i++) begin
        push_ev(MODE_W'($urandom_range(3)), KEY_W'($urandom_range(31)));
        n++;
      end
    end
  endtask

  // Random phase; optionally the sender waits for a full drain halfway through
  task automatic run_random(input int tps, input int refr, input int buzz,
                            input int send_pct, input int recv_pct,
                            input int items, input bit drain_mid);
    int count;
    int n;
    bit drained;
    count = 0;
    drained = 0;
    set_regs(tps, refr, buzz);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (count < items) begin
      if (drain_mid && !drained && count >= items / 2) begin
        wait_idle();
        drained = 1;
      end
      queue_session(n);
      count += n;
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unknown mode, silent buzzer, ignored keys, entry with clamp, commit
    set_regs(2, 1, 3);
    push_ev(MODE_NONE, KEY_TOP);
    push_ev(MODE_BUZZ, KEY_NONE);
    push_ev(MODE_KEY, KEY_DISPLAY);
    push_ev(MODE_KEY, KEY_NONE);
    push_ev(MODE_KEY, key_for_digit(4));
    push_ev(MODE_KEY, KEY_START);
    push_ev(MODE_KEY, key_for_digit(9));
    push_ev(MODE_TICK, KEY_TOP);
    push_ev(MODE_KEY, key_for_digit(6));
    push_ev(MODE_KEY, key_for_digit(9));
    push_ev(MODE_KEY, KEY_HASH);
    push_ev(MODE_KEY, KEY_PAUSE);
    push_ev(MODE_KEY, key_for_digit(3));
    push_ev(MODE_KEY, KEY_COMMIT);
    push_ev(MODE_TICK, KEY_NONE);
    push_ev(MODE_TICK, KEY_NONE);

    // Directed: no refresh, zero buzzer length, alarm then pause
    set_regs(1, 0, 0);
    push_ev(MODE_KEY, KEY_START);
    push_ev(MODE_KEY, key_for_digit(0));
    push_ev(MODE_KEY, key_for_digit(0));
    push_ev(MODE_KEY, key_for_digit(0));
    push_ev(MODE_KEY, key_for_digit(1));
    push_ev(MODE_KEY, KEY_COMMIT);
    push_ev(MODE_TICK, KEY_NONE);
    push_ev(MODE_KEY, KEY_PAUSE);
    push_ev(MODE_TICK, KEY_NONE);
    push_ev(MODE_BUZZ, KEY_NONE);
    push_ev(MODE_BUZZ, KEY_TOP);

    run_random(0, 255, 511, 71, 0, 200, 0);
    run_random(255, 0, 1, 0, 71, 200, 0);
    run_random(1, 1, 1, 25, 25, 400, 1);
    run_random($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 12),
               0, 0, 400, 0);
    run_random($urandom_range(1, 4), $urandom_range(1, 255), $urandom_range(1, 40),
               71, 0, 400, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (display_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_keypad_countdown_timer passed");
    end else begin
      $display("tb_keypad_countdown_timer failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_keypad_countdown_timer failed");
    $finish;
  end

endmodule

`default_nettype wire
